@@ src/pfa_pkg.sv @@
// Shared types and constants of the page frame allocator.
`default_nettype none

package pfa_pkg;

    // Table sizes and identifier width
    localparam int RAM_FRAMES = 256;
    localparam int SWAP_SLOTS = 512;
    localparam int PID_BITS   = 16;
    localparam int STAMP_W    = 32;

    // Derived index widths
    localparam int RAM_AW  = (RAM_FRAMES > 1) ? $clog2(RAM_FRAMES) : 1;
    localparam int SWAP_AW = (SWAP_SLOTS > 1) ? $clog2(SWAP_SLOTS) : 1;
    localparam int MAX_N   = (RAM_FRAMES > SWAP_SLOTS) ? RAM_FRAMES : SWAP_SLOTS;
    localparam int IDX_W   = (RAM_AW > SWAP_AW) ? RAM_AW : SWAP_AW;
    localparam int CNT_W   = $clog2(MAX_N + 1);

    // Port field widths
    localparam int PIDF_W  = 16;
    localparam int FRAME_W = 8;
    localparam int SLOT_W  = 9;

    // Request kinds
    localparam logic FN_ALLOC   = 1'b0;
    localparam logic FN_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_FREE     = 2'd0,
        ST_EVICT    = 2'd1,
        ST_NOSWAP   = 2'd2,
        ST_RELEASED = 2'd3
    } status_t;

    typedef struct packed {
        logic                func;
        logic [PID_BITS-1:0] pid;
    } req_t;

    typedef struct packed {
        status_t             status;
        logic [FRAME_W-1:0]  frame;
        logic [SLOT_W-1:0]   slot;
        logic [PIDF_W-1:0]   evicted;
    } res_t;

    // Core to top level status
    typedef struct packed {
        logic idle;
        logic done;
        res_t res;
    } core_stat_t;

    typedef struct packed {
        logic                used;
        logic [PID_BITS-1:0] owner;
        logic [STAMP_W-1:0]  stamp;
    } ram_ent_t;

    typedef struct packed {
        logic                used;
        logic [PID_BITS-1:0] owner;
    } swap_ent_t;

endpackage

`default_nettype wire

@@ src/pfa_core.sv @@
// Owner tables in RAM and swap memories with the scan sequencer.
`default_nettype none

module pfa_core
    import pfa_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire req_t       req,
    input  wire logic       ack,
    output core_stat_t      stat
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RAM,
        S_SWAP,
        S_DONE
    } state_t;

    localparam logic [CNT_W-1:0] RAM_END   = CNT_W'(RAM_FRAMES);
    localparam logic [CNT_W-1:0] SWAP_END  = CNT_W'(SWAP_SLOTS);
    localparam logic [CNT_W-1:0] CLR_LAST  = CNT_W'(MAX_N - 1);
    localparam logic [IDX_W-1:0] RAM_LAST  = IDX_W'(RAM_FRAMES - 1);
    localparam logic [IDX_W-1:0] SWAP_LAST = IDX_W'(SWAP_SLOTS - 1);

    // Memories
    ram_ent_t  ram_mem  [RAM_FRAMES];
    swap_ent_t swap_mem [SWAP_SLOTS];
    ram_ent_t  ram_q_reg;
    swap_ent_t swap_q_reg;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic                 pend_reg, pend_next;
    logic [IDX_W-1:0]     pidx_reg, pidx_next;
    req_t                 req_reg, req_next;
    logic [STAMP_W-1:0]   cnt_reg, cnt_next;
    logic [STAMP_W-1:0]   best_age_reg, best_age_next;
    logic [RAM_AW-1:0]    best_idx_reg, best_idx_next;
    logic [PID_BITS-1:0]  best_owner_reg, best_owner_next;
    res_t                 res_reg, res_next;

    logic                 ram_we;
    logic [RAM_AW-1:0]    ram_wa;
    ram_ent_t             ram_wd;
    logic                 swap_we;
    logic [SWAP_AW-1:0]   swap_wa;
    swap_ent_t            swap_wd;
    logic [STAMP_W-1:0]   age;

    // Memory ports: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            ram_mem[ram_wa] <= ram_wd;
        end
        ram_q_reg <= ram_mem[idx_reg[RAM_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (swap_we)
        begin
            swap_mem[swap_wa] <= swap_wd;
        end
        swap_q_reg <= swap_mem[idx_reg[SWAP_AW-1:0]];
    end

    assign age = cnt_reg - ram_q_reg.stamp;

    // Sequencer: read at idx, act on the entry read in the cycle before
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        pend_next       = 1'b0;
        pidx_next       = pidx_reg;
        req_next        = req_reg;
        cnt_next        = cnt_reg;
        best_age_next   = best_age_reg;
        best_idx_next   = best_idx_reg;
        best_owner_next = best_owner_reg;
        res_next        = res_reg;
        ram_we          = 1'b0;
        ram_wa          = pidx_reg[RAM_AW-1:0];
        ram_wd          = '0;
        swap_we         = 1'b0;
        swap_wa         = pidx_reg[SWAP_AW-1:0];
        swap_wd         = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we   = (idx_reg < RAM_END);
                ram_wa   = idx_reg[RAM_AW-1:0];
                swap_we  = (idx_reg < SWAP_END);
                swap_wa  = idx_reg[SWAP_AW-1:0];
                idx_next = idx_reg + 1'b1;
                if (idx_reg == CLR_LAST)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = req;
                    idx_next   = '0;
                    state_next = S_RAM;
                end
            end

            S_RAM:
            begin
                if (idx_reg < RAM_END)
                begin
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                    pidx_next = idx_reg[IDX_W-1:0];
                end
                if (pend_reg)
                begin
                    if (req_reg.func == FN_RELEASE)
                    begin
                        if (ram_q_reg.used && ram_q_reg.owner == req_reg.pid)
                        begin
                            ram_we      = 1'b1;
                            ram_wd      = ram_q_reg;
                            ram_wd.used = 1'b0;
                        end
                        if (pidx_reg == RAM_LAST)
                        begin
                            idx_next   = '0;
                            pend_next  = 1'b0;
                            state_next = S_SWAP;
                        end
                    end
                    else if (!ram_q_reg.used)
                    begin
                        // first free frame
                        ram_we         = 1'b1;
                        ram_wd.used    = 1'b1;
                        ram_wd.owner   = req_reg.pid;
                        ram_wd.stamp   = cnt_reg;
                        cnt_next       = cnt_reg + 1'b1;
                        res_next.status  = ST_FREE;
                        res_next.frame   = FRAME_W'(32'(pidx_reg));
                        res_next.slot    = '0;
                        res_next.evicted = '0;
                        pend_next      = 1'b0;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        // track oldest frame, lowest index on ties
                        if (pidx_reg == '0 || age > best_age_reg)
                        begin
                            best_age_next   = age;
                            best_idx_next   = pidx_reg[RAM_AW-1:0];
                            best_owner_next = ram_q_reg.owner;
                        end
                        if (pidx_reg == RAM_LAST)
                        begin
                            idx_next   = '0;
                            pend_next  = 1'b0;
                            state_next = S_SWAP;
                        end
                    end
                end
            end

            S_SWAP:
            begin
                if (idx_reg < SWAP_END)
                begin
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                    pidx_next = idx_reg[IDX_W-1:0];
                end
                if (pend_reg)
                begin
                    if (req_reg.func == FN_RELEASE)
                    begin
                        if (swap_q_reg.used && swap_q_reg.owner == req_reg.pid)
                        begin
                            swap_we      = 1'b1;
                            swap_wd      = swap_q_reg;
                            swap_wd.used = 1'b0;
                        end
                        if (pidx_reg == SWAP_LAST)
                        begin
                            res_next.status  = ST_RELEASED;
                            res_next.frame   = '0;
                            res_next.slot    = '0;
                            res_next.evicted = '0;
                            pend_next        = 1'b0;
                            state_next       = S_DONE;
                        end
                    end
                    else if (!swap_q_reg.used)
                    begin
                        // evict oldest frame into this slot
                        swap_we          = 1'b1;
                        swap_wd.used     = 1'b1;
                        swap_wd.owner    = best_owner_reg;
                        ram_we           = 1'b1;
                        ram_wa           = best_idx_reg;
                        ram_wd.used      = 1'b1;
                        ram_wd.owner     = req_reg.pid;
                        ram_wd.stamp     = cnt_reg;
                        cnt_next         = cnt_reg + 1'b1;
                        res_next.status  = ST_EVICT;
                        res_next.frame   = FRAME_W'(32'(best_idx_reg));
                        res_next.slot    = SLOT_W'(32'(pidx_reg));
                        res_next.evicted = PIDF_W'(32'(best_owner_reg));
                        pend_next        = 1'b0;
                        state_next       = S_DONE;
                    end
                    else if (pidx_reg == SWAP_LAST)
                    begin
                        res_next.status  = ST_NOSWAP;
                        res_next.frame   = '0;
                        res_next.slot    = '0;
                        res_next.evicted = '0;
                        pend_next        = 1'b0;
                        state_next       = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (ack)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            idx_reg        <= '0;
            pend_reg       <= 1'b0;
            pidx_reg       <= '0;
            req_reg        <= '0;
            cnt_reg        <= '0;
            best_age_reg   <= '0;
            best_idx_reg   <= '0;
            best_owner_reg <= '0;
            res_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            pend_reg       <= pend_next;
            pidx_reg       <= pidx_next;
            req_reg        <= req_next;
            cnt_reg        <= cnt_next;
            best_age_reg   <= best_age_next;
            best_idx_reg   <= best_idx_next;
            best_owner_reg <= best_owner_next;
            res_reg        <= res_next;
        end
    end

    assign stat.idle = (state_reg == S_IDLE);
    assign stat.done = (state_reg == S_DONE);
    assign stat.res  = res_reg;

`ifndef NO_ASSERTIONS
    // Load counter only ever steps by one
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(cnt_reg) |-> cnt_reg == $past(cnt_reg) + 32'd1)
        else $error("load counter jumped");

    // A new item is taken only while idle
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == S_IDLE)
        else $error("start outside idle");

    // No table writes while idle or holding a result
    a_no_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_DONE) |-> !ram_we && !swap_we)
        else $error("table write while idle");

    // Scan writes act only on a returned entry
    a_wr_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg == S_RAM) |-> pend_reg)
        else $error("write without read data");

    // Only an eviction reports a slot or an evicted owner
    a_res_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.done && res_reg.status != ST_EVICT) |->
            res_reg.slot == '0 && res_reg.evicted == '0)
        else $error("stray eviction fields");
`endif

endmodule

`default_nettype wire

@@ src/page_frame_alloc_fifo_swap_unit.sv @@
// Top level: stream ports, request capture and output register.
`default_nettype none

// Page frame allocator with oldest-first replacement into swap. Each item
// either allocates one RAM frame to a process (evicting the oldest loaded
// frame to the lowest free swap slot when RAM is full) or releases every
// frame and slot the process owns; each item gives exactly one result.
// Both owner tables sit in single-port-read memories scanned one entry per
// cycle with a registered read, so the scan sets the rate. An allocation
// stops at the first free frame, or at the first free swap slot when it
// evicts; an allocation that finds swap full fails, and such a failure and
// every release walk both tables. After reset the block clears both tables
// before taking items. A finished result waits in an output register; the
// block is ready for the next item once the result moves there, while the
// result may still be unclaimed.
module page_frame_alloc_fifo_swap_unit
    import pfa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] process_id
    input  wire logic [0:0]  s_axis_tuser,   // [0] func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [7:0] ram_frame, [16:8] swap_slot,
                                             // [32:17] evicted_process, [39:33] zero
    output logic [1:0]       m_axis_tuser    // [1:0] status
);

    core_stat_t stat;
    req_t       req;
    logic       start;
    logic       load;
    logic       out_valid_reg, out_valid_next;
    res_t       out_res_reg, out_res_next;

    // Input item capture
    assign s_axis_tready = stat.idle;
    assign start         = s_axis_tvalid && stat.idle;
    assign req.func      = s_axis_tuser[0];
    assign req.pid       = PID_BITS'(32'(s_axis_tdata));

    pfa_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .ack   (load),
        .stat  (stat)
    );

    // Output register takes a result when empty or being drained
    assign load = stat.done && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_res_next   = stat.res;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_res_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            out_res_reg   <= out_res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.status;
    assign m_axis_tdata  = {7'd0, out_res_reg.evicted, out_res_reg.slot, out_res_reg.frame};

endmodule

`default_nettype wire
